// File: rtl/hpd_pkg.sv
// Shared types, constants and register codes for the heading PID core.
package hpd_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int GAIN_SHIFT_DEF = 16;

  localparam int HDG_W      = 16;
  localparam int GAIN_W     = 20;
  localparam int LIM_W      = 24;
  localparam int BAND_W     = 15;
  localparam int SUM_W      = 25;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_MEAS = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INT_GAIN       = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_SUM_LIMIT      = 3'd3,
    REG_ERROR_BAND     = 3'd4,
    REG_TURN_DEADBAND  = 3'd5,
    REG_TURN_MAX       = 3'd6,
    REG_SPEED_DEADBAND = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] int_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [LIM_W-1:0]  sum_limit;
    logic [BAND_W-1:0] error_band;
    logic [BAND_W-1:0] turn_deadband;
    logic [BAND_W-1:0] turn_max;
    logic [BAND_W-1:0] speed_deadband;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:      20'd25736,
    int_gain:       20'd51,
    deriv_gain:     20'd64340,
    sum_limit:      24'd521520,
    error_band:     15'd910,
    turn_deadband:  15'd1229,
    turn_max:       15'd4096,
    speed_deadband: 15'd1229
  };

endpackage

// File: rtl/hpd_track.sv
// Controller state, wrapped heading error and clamped error sum (first stage).
module hpd_track import hpd_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cfg_t                         cfg,
  input  logic                         in_v,
  output logic                         up_ready,
  input  logic                         op,
  input  logic signed [HDG_W-1:0]      target_heading,
  input  logic signed [HDG_W-1:0]      target_speed,
  input  logic signed [HDG_W-1:0]      measured_heading,
  output logic                         s1_valid_r,
  input  logic                         dn_ready,
  output logic signed [ANGLE_BITS-1:0] s1_err_r,
  output logic signed [SUM_W-1:0]      s1_sum_r,
  output logic signed [ANGLE_BITS:0]   s1_diff_r,
  output logic signed [HDG_W-1:0]      s1_speed_r
);

  localparam int EXT_W = (ANGLE_BITS > HDG_W) ? ANGLE_BITS : HDG_W;
  localparam int CMP_W = (ANGLE_BITS > BAND_W) ? ANGLE_BITS : BAND_W;
  localparam int SUM_X = LIM_W + 2;

  logic signed [HDG_W-1:0]      goal_heading_r;
  logic signed [HDG_W-1:0]      goal_speed_r;
  logic signed [SUM_W-1:0]      error_sum_r;
  logic signed [ANGLE_BITS-1:0] last_error_r;
  logic                         command_seen_r;

  logic                         take;
  logic                         is_meas;
  logic signed [EXT_W-1:0]      gh_x;
  logic signed [EXT_W-1:0]      mh_x;
  logic signed [EXT_W-1:0]      dh;
  logic signed [ANGLE_BITS-1:0] e_raw;
  logic [ANGLE_BITS-1:0]        e_mag;
  logic                         below;
  logic signed [ANGLE_BITS-1:0] e_z;
  logic signed [SUM_X-1:0]      sum_add;
  logic signed [SUM_X-1:0]      lim_x;
  logic signed [SUM_X-1:0]      sum_clamp;
  logic signed [SUM_W-1:0]      sum_new;
  logic signed [ANGLE_BITS:0]   diff;
  logic signed [HDG_W:0]        spd_x;
  logic [HDG_W:0]               spd_mag;
  logic signed [HDG_W-1:0]      speed_new;

  assign up_ready = !s1_valid_r || dn_ready;
  assign take     = in_v && up_ready;
  assign is_meas  = (op_t'(op) == OP_MEAS);

  // error wraps modulo one full turn of ANGLE_BITS
  assign gh_x  = EXT_W'(goal_heading_r);
  assign mh_x  = EXT_W'(measured_heading);
  assign dh    = gh_x - mh_x;
  assign e_raw = dh[ANGLE_BITS-1:0];
  assign e_mag = e_raw[ANGLE_BITS-1] ? ANGLE_BITS'(-e_raw) : ANGLE_BITS'(e_raw);
  assign below = CMP_W'(e_mag) < CMP_W'(cfg.error_band);
  assign e_z   = below ? '0 : e_raw;

  assign sum_add   = SUM_X'(error_sum_r) + SUM_X'(e_raw);
  assign lim_x     = $signed({{(SUM_X-LIM_W){1'b0}}, cfg.sum_limit});
  assign sum_clamp = (sum_add > lim_x)  ? lim_x :
                     (sum_add < -lim_x) ? -lim_x : sum_add;
  assign sum_new   = below ? '0 : SUM_W'(sum_clamp);
  assign diff      = (ANGLE_BITS+1)'(e_z) - (ANGLE_BITS+1)'(last_error_r);

  assign spd_x     = (HDG_W+1)'(target_speed);
  assign spd_mag   = spd_x[HDG_W] ? (HDG_W+1)'(-spd_x) : (HDG_W+1)'(spd_x);
  assign speed_new = (spd_mag < (HDG_W+1)'(cfg.speed_deadband)) ? '0 : target_speed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_heading_r <= '0;
      goal_speed_r   <= '0;
      error_sum_r    <= '0;
      last_error_r   <= '0;
      command_seen_r <= 1'b0;
      s1_valid_r     <= 1'b0;
    end else begin
      if (take) begin
        if (!is_meas) begin
          goal_heading_r <= target_heading;
          goal_speed_r   <= speed_new;
          error_sum_r    <= '0;
          last_error_r   <= '0;
          command_seen_r <= 1'b1;
        end else if (command_seen_r) begin
          error_sum_r  <= sum_new;
          last_error_r <= e_z;
        end
      end
      if (up_ready) begin
        s1_valid_r <= in_v && is_meas && command_seen_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && is_meas) begin
      s1_err_r   <= e_z;
      s1_sum_r   <= sum_new;
      s1_diff_r  <= diff;
      s1_speed_r <= goal_speed_r;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_sets_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_meas) |=> command_seen_r)
    else $error("command transfer did not mark a command as seen");

  a_cmd_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && !is_meas) |=> !s1_valid_r)
    else $error("command transfer produced a result");

  a_meas_result: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_meas && command_seen_r) |=> s1_valid_r)
    else $error("measurement after command produced no result");

  a_no_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (take && is_meas && !command_seen_r) |=>
      ($stable(error_sum_r) && $stable(last_error_r) && !s1_valid_r))
    else $error("measurement before any command changed state");
`endif

endmodule

// File: rtl/hpd_mult.sv
// Registered P, I and D gain products (second stage).
module hpd_mult import hpd_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfg_t                                cfg,
  input  logic                                in_v,
  output logic                                up_ready,
  input  logic signed [ANGLE_BITS-1:0]        err,
  input  logic signed [SUM_W-1:0]             err_sum,
  input  logic signed [ANGLE_BITS:0]          err_diff,
  input  logic signed [HDG_W-1:0]             speed,
  output logic                                s2_valid_r,
  input  logic                                dn_ready,
  output logic signed [GAIN_W+ANGLE_BITS:0]   prod_p_r,
  output logic signed [GAIN_W+SUM_W:0]        prod_i_r,
  output logic signed [GAIN_W+ANGLE_BITS+1:0] prod_d_r,
  output logic signed [ANGLE_BITS-1:0]        s2_err_r,
  output logic signed [HDG_W-1:0]             s2_speed_r
);

  logic signed [GAIN_W:0] pg_s;
  logic signed [GAIN_W:0] ig_s;
  logic signed [GAIN_W:0] dg_s;
  logic                   take;

  assign pg_s     = $signed({1'b0, cfg.prop_gain});
  assign ig_s     = $signed({1'b0, cfg.int_gain});
  assign dg_s     = $signed({1'b0, cfg.deriv_gain});
  assign up_ready = !s2_valid_r || dn_ready;
  assign take     = in_v && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (up_ready) begin
      s2_valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_p_r   <= pg_s * err;
      prod_i_r   <= ig_s * err_sum;
      prod_d_r   <= dg_s * err_diff;
      s2_err_r   <= err;
      s2_speed_r <= speed;
    end
  end

endmodule

// File: rtl/hpd_shape.sv
// Drive sum, gain shift, turn deadband, turn clamp and result register.
module hpd_shape import hpd_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int GAIN_SHIFT = GAIN_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cfg_t                                cfg,
  input  logic                                in_v,
  output logic                                up_ready,
  input  logic signed [GAIN_W+ANGLE_BITS:0]   prod_p,
  input  logic signed [GAIN_W+SUM_W:0]        prod_i,
  input  logic signed [GAIN_W+ANGLE_BITS+1:0] prod_d,
  input  logic signed [ANGLE_BITS-1:0]        err,
  input  logic signed [HDG_W-1:0]             speed,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [HDG_W-1:0]             out_speed_cmd,
  output logic signed [HDG_W-1:0]             out_turn_cmd,
  output logic signed [HDG_W-1:0]             out_heading_error
);

  localparam int SW = GAIN_W + SUM_W + 3;

  logic signed [SW-1:0]    total;
  logic signed [SW-1:0]    drive;
  logic signed [SW-1:0]    db_x;
  logic signed [SW-1:0]    tmax_x;
  logic signed [SW-1:0]    drive_db;
  logic signed [SW-1:0]    drive_cl;
  logic                    take;
  logic                    out_valid_r;
  logic signed [HDG_W-1:0] speed_r;
  logic signed [HDG_W-1:0] turn_r;
  logic signed [HDG_W-1:0] herr_r;

  assign total  = SW'(prod_p) + SW'(prod_i) + SW'(prod_d);
  // arithmetic shift rounds toward minus infinity
  assign drive  = total >>> GAIN_SHIFT;
  assign db_x   = $signed({{(SW-BAND_W){1'b0}}, cfg.turn_deadband});
  assign tmax_x = $signed({{(SW-BAND_W){1'b0}}, cfg.turn_max});

  always_comb begin
    drive_db = drive;
    if (drive > 0 && drive < db_x) begin
      drive_db = db_x;
    end else if (drive < 0 && drive > -db_x) begin
      drive_db = -db_x;
    end
    drive_cl = drive_db;
    if (drive_db > tmax_x) begin
      drive_cl = tmax_x;
    end else if (drive_db < -tmax_x) begin
      drive_cl = -tmax_x;
    end
  end

  assign up_ready = !out_valid_r || out_ready;
  assign take     = in_v && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      speed_r <= speed;
      turn_r  <= HDG_W'(drive_cl);
      herr_r  <= HDG_W'(err);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_speed_cmd     = speed_r;
  assign out_turn_cmd      = turn_r;
  assign out_heading_error = herr_r;

endmodule

// File: rtl/heading_pid_with_deadbands_core.sv
// Pipeline: an input transfer passes through the input reg, error stage, product
// stage and result reg; commands and measurements before any command give no
// result. Throughput: one item per cycle while out_ready is not held low, four-register pipeline.
// Reset (synchronous, active low): registers back to defaults, goal, error sum and
// last error cleared, no command seen, pipeline empty. No clearing pass.
module heading_pid_with_deadbands_core import hpd_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int GAIN_SHIFT = GAIN_SHIFT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_op,
  input  logic signed [HDG_W-1:0]      in_target_heading,
  input  logic signed [HDG_W-1:0]      in_target_speed,
  input  logic signed [HDG_W-1:0]      in_measured_heading,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [HDG_W-1:0]      out_speed_cmd,
  output logic signed [HDG_W-1:0]      out_turn_cmd,
  output logic signed [HDG_W-1:0]      out_heading_error
);

  cfg_t                          cfg_r;
  logic                          s0_valid_r;
  logic                          s0_op_r;
  logic signed [HDG_W-1:0]       s0_target_heading_r;
  logic signed [HDG_W-1:0]       s0_target_speed_r;
  logic signed [HDG_W-1:0]       s0_measured_heading_r;
  logic                          s0_ready;

  logic                          s1_valid;
  logic                          s1_ready;
  logic signed [ANGLE_BITS-1:0]  s1_err;
  logic signed [SUM_W-1:0]       s1_sum;
  logic signed [ANGLE_BITS:0]    s1_diff;
  logic signed [HDG_W-1:0]       s1_speed;

  logic                                s2_valid;
  logic                                s2_ready;
  logic signed [GAIN_W+ANGLE_BITS:0]   s2_prod_p;
  logic signed [GAIN_W+SUM_W:0]        s2_prod_i;
  logic signed [GAIN_W+ANGLE_BITS+1:0] s2_prod_d;
  logic signed [ANGLE_BITS-1:0]        s2_err;
  logic signed [HDG_W-1:0]             s2_speed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_PROP_GAIN:      cfg_r.prop_gain      <= cfg_wdata[GAIN_W-1:0];
        REG_INT_GAIN:       cfg_r.int_gain       <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg_r.deriv_gain     <= cfg_wdata[GAIN_W-1:0];
        REG_SUM_LIMIT:      cfg_r.sum_limit      <= cfg_wdata[LIM_W-1:0];
        REG_ERROR_BAND:     cfg_r.error_band     <= cfg_wdata[BAND_W-1:0];
        REG_TURN_DEADBAND:  cfg_r.turn_deadband  <= cfg_wdata[BAND_W-1:0];
        REG_TURN_MAX:       cfg_r.turn_max       <= cfg_wdata[BAND_W-1:0];
        REG_SPEED_DEADBAND: cfg_r.speed_deadband <= cfg_wdata[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // input register; refills in the same cycle it hands off
  assign in_ready = !s0_valid_r || s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_op_r               <= in_op;
      s0_target_heading_r   <= in_target_heading;
      s0_target_speed_r     <= in_target_speed;
      s0_measured_heading_r <= in_measured_heading;
    end
  end

  hpd_track #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_v             (s0_valid_r),
    .up_ready         (s0_ready),
    .op               (s0_op_r),
    .target_heading   (s0_target_heading_r),
    .target_speed     (s0_target_speed_r),
    .measured_heading (s0_measured_heading_r),
    .s1_valid_r       (s1_valid),
    .dn_ready         (s1_ready),
    .s1_err_r         (s1_err),
    .s1_sum_r         (s1_sum),
    .s1_diff_r        (s1_diff),
    .s1_speed_r       (s1_speed)
  );

  hpd_mult #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_v       (s1_valid),
    .up_ready   (s1_ready),
    .err        (s1_err),
    .err_sum    (s1_sum),
    .err_diff   (s1_diff),
    .speed      (s1_speed),
    .s2_valid_r (s2_valid),
    .dn_ready   (s2_ready),
    .prod_p_r   (s2_prod_p),
    .prod_i_r   (s2_prod_i),
    .prod_d_r   (s2_prod_d),
    .s2_err_r   (s2_err),
    .s2_speed_r (s2_speed)
  );

  hpd_shape #(
    .ANGLE_BITS(ANGLE_BITS),
    .GAIN_SHIFT(GAIN_SHIFT)
  ) u_shape (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_v              (s2_valid),
    .up_ready          (s2_ready),
    .prod_p            (s2_prod_p),
    .prod_i            (s2_prod_i),
    .prod_d            (s2_prod_d),
    .err               (s2_err),
    .speed             (s2_speed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_speed_cmd     (out_speed_cmd),
    .out_turn_cmd      (out_turn_cmd),
    .out_heading_error (out_heading_error)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for heading_pid_with_deadbands_core: predicts each steering result.
`timescale 1ns / 1ps

module tb_top;
  import hpd_pkg::*;

  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    op_t                    op;
    logic signed [HDG_W-1:0] target_heading;
    logic signed [HDG_W-1:0] target_speed;
    logic signed [HDG_W-1:0] measured_heading;
  } hdg_item_t;

  typedef struct {
    logic signed [HDG_W-1:0] speed_cmd;
    logic signed [HDG_W-1:0] turn_cmd;
    logic signed [HDG_W-1:0] heading_error;
  } steer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                    in_valid = 1'b0;
  logic                    in_ready;
  op_t                     in_op = OP_CMD;
  logic signed [HDG_W-1:0] in_target_heading = '0;
  logic signed [HDG_W-1:0] in_target_speed = '0;
  logic signed [HDG_W-1:0] in_measured_heading = '0;

  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [HDG_W-1:0] out_speed_cmd;
  logic signed [HDG_W-1:0] out_turn_cmd;
  logic signed [HDG_W-1:0] out_heading_error;

  always #5 clk = ~clk;

  heading_pid_with_deadbands_core i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_target_heading  (in_target_heading),
    .in_target_speed    (in_target_speed),
    .in_measured_heading(in_measured_heading),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_speed_cmd      (out_speed_cmd),
    .out_turn_cmd       (out_turn_cmd),
    .out_heading_error  (out_heading_error)
  );

  // Regulator copy: registers and state as seen by accepted items
  cfg_t                    cfg_model = CFG_RESET;
  logic signed [HDG_W-1:0] goal_hdg = '0;
  logic signed [HDG_W-1:0] goal_spd = '0;
  longint                  err_sum = 0;
  longint                  last_err = 0;
  bit                      cmd_seen = 1'b0;

  hdg_item_t pending_items[$];
  steer_t    expected_steer[$];
  hdg_item_t cur_item;
  steer_t    want;

  int mismatches = 0;
  int idle_odds = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int stuck_cycles = 0;
  logic signed [HDG_W-1:0] stim_goal = '0;

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void pid_step(hdg_item_t it);
    logic [HDG_W-1:0] d;
    longint e, drive, lim, dband, tmax;
    steer_t r;
    if (it.op == OP_CMD) begin
      goal_hdg = it.target_heading;
      goal_spd = (mag(longint'(it.target_speed)) < longint'(cfg_model.speed_deadband)) ?
                 '0 : it.target_speed;
      err_sum  = 0;
      last_err = 0;
      cmd_seen = 1'b1;
      return;
    end
    if (!cmd_seen)
      return;
    d = goal_hdg - it.measured_heading;
    e = longint'($signed(d));
    if (mag(e) < longint'(cfg_model.error_band)) begin
      e = 0;
      err_sum = 0;
    end else begin
      lim = longint'(cfg_model.sum_limit);
      err_sum = err_sum + e;
      if (err_sum > lim) err_sum = lim;
      if (err_sum < -lim) err_sum = -lim;
    end
    drive = longint'(cfg_model.prop_gain) * e
          + longint'(cfg_model.int_gain) * err_sum
          + longint'(cfg_model.deriv_gain) * (e - last_err);
    drive = drive >>> GAIN_SHIFT_DEF;
    dband = longint'(cfg_model.turn_deadband);
    if (drive != 0 && mag(drive) < dband)
      drive = (drive > 0) ? dband : -dband;
    tmax = longint'(cfg_model.turn_max);
    if (drive > tmax) drive = tmax;
    if (drive < -tmax) drive = -tmax;
    last_err = e;
    r.speed_cmd     = goal_spd;
    r.turn_cmd      = drive[HDG_W-1:0];
    r.heading_error = e[HDG_W-1:0];
    expected_steer.push_back(r);
  endfunction

  function automatic void check_field(string fld, logic signed [HDG_W-1:0] exp_v,
                                      logic signed [HDG_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Sender: one transfer per accepted item, random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready)
        pid_step(cur_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          in_valid            <= 1'b1;
          in_op               <= cur_item.op;
          in_target_heading   <= cur_item.target_heading;
          in_target_speed     <= cur_item.target_speed;
          in_measured_heading <= cur_item.measured_heading;
        end
      end
    end
  end

  // Receiver: checks each result transfer, stalls at random or on a long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_steer.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual speed %0d turn %0d error %0d",
                   $time, out_speed_cmd, out_turn_cmd, out_heading_error);
          mismatches++;
        end else begin
          want = expected_steer.pop_front();
          check_field("speed_cmd", want.speed_cmd, out_speed_cmd);
          check_field("turn_cmd", want.turn_cmd, out_turn_cmd);
          check_field("heading_error", want.heading_error, out_heading_error);
        end
      end
      if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("heading_pid_with_deadbands_core regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_PROP_GAIN:      cfg_model.prop_gain      = val[GAIN_W-1:0];
      REG_INT_GAIN:       cfg_model.int_gain       = val[GAIN_W-1:0];
      REG_DERIV_GAIN:     cfg_model.deriv_gain     = val[GAIN_W-1:0];
      REG_SUM_LIMIT:      cfg_model.sum_limit      = val[LIM_W-1:0];
      REG_ERROR_BAND:     cfg_model.error_band     = val[BAND_W-1:0];
      REG_TURN_DEADBAND:  cfg_model.turn_deadband  = val[BAND_W-1:0];
      REG_TURN_MAX:       cfg_model.turn_max       = val[BAND_W-1:0];
      REG_SPEED_DEADBAND: cfg_model.speed_deadband = val[BAND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_cfg(cfg_t c);
    write_reg(REG_PROP_GAIN, CFG_DATA_W'(c.prop_gain));
    write_reg(REG_INT_GAIN, CFG_DATA_W'(c.int_gain));
    write_reg(REG_DERIV_GAIN, CFG_DATA_W'(c.deriv_gain));
    write_reg(REG_SUM_LIMIT, CFG_DATA_W'(c.sum_limit));
    write_reg(REG_ERROR_BAND, CFG_DATA_W'(c.error_band));
    write_reg(REG_TURN_DEADBAND, CFG_DATA_W'(c.turn_deadband));
    write_reg(REG_TURN_MAX, CFG_DATA_W'(c.turn_max));
    write_reg(REG_SPEED_DEADBAND, CFG_DATA_W'(c.speed_deadband));
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait out every expected result, then the pipeline depth for trailing commands
  task automatic settle();
    while (pending_items.size() != 0 || in_valid || expected_steer.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic push_cmd(logic signed [HDG_W-1:0] hdg, logic signed [HDG_W-1:0] spd);
    hdg_item_t it;
    it.op               = OP_CMD;
    it.target_heading   = hdg;
    it.target_speed     = spd;
    it.measured_heading = HDG_W'($urandom);
    stim_goal = hdg;
    pending_items.push_back(it);
  endtask

  task automatic push_meas(logic signed [HDG_W-1:0] hdg);
    hdg_item_t it;
    it.op               = OP_MEAS;
    it.target_heading   = HDG_W'($urandom);
    it.target_speed     = HDG_W'($urandom);
    it.measured_heading = hdg;
    pending_items.push_back(it);
  endtask

  function automatic logic signed [HDG_W-1:0] heading_near_goal();
    int off;
    int band;
    band = int'(cfg_model.error_band);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: off = $urandom_range(0, 4000) - 2000;
      4, 5, 6:    off = $urandom_range(0, 20000) - 10000;
      7: begin
        case ($urandom_range(0, 3))
          0: off = band;
          1: off = -band;
          2: off = band - 1;
          default: off = 1 - band;
        endcase
      end
      8: off = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
      default: return HDG_W'($urandom);
    endcase
    return HDG_W'(int'(stim_goal) - off);
  endfunction

  // Mostly measurements around the goal, with a command now and then
  task automatic push_random(int n);
    int spd;
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1) != 0) begin
          spd = $urandom;
        end else begin
          spd = int'(cfg_model.speed_deadband) + $urandom_range(0, 64) - 32;
          if ($urandom_range(0, 1) != 0) spd = -spd;
        end
        push_cmd(HDG_W'($urandom), HDG_W'(spd));
      end else begin
        push_meas(heading_near_goal());
      end
    end
  endtask

  initial begin
    cfg_t c;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    idle_odds = 6;

    // measurements before any command produce nothing
    push_meas(16'sh7FFF);
    push_meas(-16'sh8000);
    push_cmd(16'sd0, -16'sh8000);
    push_meas(16'sd0);
    push_meas(-16'sh8000);
    push_meas(16'sh7FFF);
    // error band edges, then repeated small errors to lift drive to the deadband
    push_meas(16'sd909);
    push_meas(16'sd910);
    push_meas(-16'sd910);
    push_meas(-16'sd910);
    push_meas(16'sd910);
    push_meas(16'sd910);
    push_cmd(16'sh7FFF, 16'sd1228);
    push_meas(16'sh7FFF);
    push_meas(-16'sd1);
    push_cmd(-16'sh8000, 16'sd1229);
    push_meas(16'sh7FFF);
    push_cmd(16'sd100, -16'sd1228);
    push_cmd(-16'sd100, 16'sh7FFF);
    push_meas(-16'sd1100);
    push_meas(-16'sd1100);
    push_meas(-16'sd1100);
    settle();

    // full-scale gains, no error band, deadband above the turn clamp
    c.prop_gain      = 20'hFFFFF;
    c.int_gain       = 20'hFFFFF;
    c.deriv_gain     = 20'hFFFFF;
    c.sum_limit      = 24'hFFFFFF;
    c.error_band     = 15'd0;
    c.turn_deadband  = 15'h7FFF;
    c.turn_max       = 15'd100;
    c.speed_deadband = 15'd0;
    load_cfg(c);
    push_random(100);
    settle();

    c = '0;
    load_cfg(c);
    idle_odds = 3;
    push_random(50);
    settle();

    // widest bands: only values of magnitude 32767 or more get through
    c.prop_gain      = 20'd40000;
    c.int_gain       = 20'd300;
    c.deriv_gain     = 20'd90000;
    c.sum_limit      = 24'd100000;
    c.error_band     = 15'h7FFF;
    c.turn_deadband  = 15'd0;
    c.turn_max       = 15'h7FFF;
    c.speed_deadband = 15'h7FFF;
    load_cfg(c);
    idle_odds = 8;
    push_random(70);
    settle();

    c.prop_gain      = GAIN_W'($urandom_range(0, 20'hFFFFF));
    c.int_gain       = GAIN_W'($urandom_range(0, 20'hFFFFF));
    c.deriv_gain     = GAIN_W'($urandom_range(0, 20'hFFFFF));
    c.sum_limit      = LIM_W'($urandom_range(0, 24'hFFFFFF));
    c.error_band     = BAND_W'($urandom_range(0, 4000));
    c.turn_deadband  = BAND_W'($urandom_range(0, 3000));
    c.turn_max       = BAND_W'($urandom_range(0, 15'h7FFF));
    c.speed_deadband = BAND_W'($urandom_range(0, 15'h7FFF));
    load_cfg(c);
    idle_odds = 4;
    push_random(120);
    // receiver holds off while items keep coming so the input backs up
    holds_asked++;
    settle();

    load_cfg(CFG_RESET);
    idle_odds = 0;
    push_random(150);

    while (pending_items.size() != 0 || in_valid || expected_steer.size() != 0)
      @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("heading_pid_with_deadbands_core regression: pass");
    end else begin
      $display("heading_pid_with_deadbands_core regression: fail");
    end
    $finish;
  end

endmodule
